>>> rtl/core/substring_first_match_finder_defines.svh
// Assertion macros for the substring first-match finder.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH

`ifndef SYNTH
// Clocked check, off while reset is asserted.
`define SFMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sfmf assertion failed");
// Clocked check that also holds during reset.
`define SFMF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sfmf assertion failed");
`else
`define SFMF_ASSERT(lbl, prop)
`define SFMF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/sfmf_pkg.sv
// Package: constants, types and register codes of the substring first-match finder.
`timescale 1ns / 1ps
package sfmf_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int POS_W       = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int SEL_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int BYTE_W      = 8;
  localparam int REG_W       = 64;
  localparam int LEN_REG_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_POS_W   = 32;
  localparam int OUT_FIELD_W = 1 + OUT_POS_W + 1;
  localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN = 2'd0,
    CFG_PAT_LO  = 2'd1,
    CFG_PAT_HI  = 2'd2
  } cfg_idx_e;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_arr_t;

  // Per-cycle control shared by all window cells.
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage

>>> rtl/core/substring_first_match_finder.sv
// The result for a text is registered and appears in the cycle after its last byte is transferred.
// Throughput: one text byte per cycle; a row of window cells shifts and compares in parallel.
// Input stalls only while a result sits in the output register and the sink is not ready.
// Reset (rst_ni low, async) clears the search state, the result valid flag and the
// configuration registers; window bytes and result data are not reset, their valid bits are.
`timescale 1ns / 1ps
module substring_first_match_finder import sfmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  // text stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [BYTE_W-1:0]    s_axis_tdata_i,   // [7:0] text_byte
  input  logic                 s_axis_tlast_i,   // end_of_text
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]     m_axis_tdata_o    // [0] found, [32:1] match_position,
                                                 // [33] too_long, rest zero
);

`include "substring_first_match_finder_defines.svh"

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Configuration registers
  logic [LEN_REG_W-1:0] pat_len_q;
  logic [REG_W-1:0]     pat_lo_q, pat_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[LEN_REG_W-1:0];
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp length to the window depth and lay out the pattern bytes.
  logic [LEN_W-1:0] len_used;
  pat_arr_t         pattern;

  assign len_used = (pat_len_q > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : LEN_W'(pat_len_q);

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k < 8) begin
        pattern[k] = pat_lo_q[k*BYTE_W +: BYTE_W];
      end else begin
        pattern[k] = pat_hi_q[(k-8)*BYTE_W +: BYTE_W];
      end
    end
  end

  // Handshake: a new byte goes in whenever the result register is free or draining.
  logic in_xfer, last_xfer;
  logic out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign last_xfer       = in_xfer && s_axis_tlast_i;

  // Search state
  logic [POS_W-1:0] byte_index_q, byte_index_d;
  logic             ovf_q, ovf_d;
  logic             hit_valid_q, hit_valid_d;
  logic [POS_W-1:0] hit_start_q, hit_start_d;

  // Window cell row: once the counter is exhausted the window freezes.
  cell_ctrl_t                          cell_ctrl;
  logic [PATTERN_MAX:0][BYTE_W-1:0]    chain_byte;
  logic [PATTERN_MAX:0]                chain_valid;
  logic [PATTERN_MAX-1:0]              cell_hit;

  assign cell_ctrl.shift = in_xfer && !ovf_q;
  assign cell_ctrl.clear = last_xfer;
  assign cell_ctrl.len   = len_used;
  assign chain_byte[0]   = s_axis_tdata_i;
  assign chain_valid[0]  = 1'b1;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    sfmf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .cell_idx_i (SEL_W'(i)),
      .pattern_i  (pattern),
      .byte_i     (chain_byte[i]),
      .valid_i    (chain_valid[i]),
      .byte_o     (chain_byte[i+1]),
      .valid_o    (chain_valid[i+1]),
      .hit_o      (cell_hit[i])
    );
  end

  // A full match needs a non-empty pattern and every cell in use to agree.
  logic match;
  assign match = (len_used != '0) && (&cell_hit);

  always_comb begin
    byte_index_d = byte_index_q;
    ovf_d        = ovf_q;
    hit_valid_d  = hit_valid_q;
    hit_start_d  = hit_start_q;
    if (in_xfer && !ovf_q) begin
      if (!hit_valid_q && match) begin
        hit_valid_d = 1'b1;
        // start = pos - (len - 1), modulo the counter width
        hit_start_d = byte_index_q - POS_W'(len_used) + POS_W'(1);
      end
      if (byte_index_q == POS_MAX) begin
        ovf_d = 1'b1;
      end else begin
        byte_index_d = byte_index_q + POS_W'(1);
      end
    end
  end

  // Result fields for the text that ends with this transfer.
  logic                 res_found;
  logic [OUT_POS_W-1:0] res_pos;

  always_comb begin
    if (len_used == '0) begin
      res_found = 1'b1;
      res_pos   = '0;
    end else if (hit_valid_d) begin
      res_found = 1'b1;
      res_pos   = OUT_POS_W'(hit_start_d);
    end else begin
      res_found = 1'b0;
      res_pos   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      ovf_q        <= 1'b0;
      hit_valid_q  <= 1'b0;
      hit_start_q  <= '0;
    end else if (last_xfer) begin
      // end of text: back to a clean search
      byte_index_q <= '0;
      ovf_q        <= 1'b0;
      hit_valid_q  <= 1'b0;
      hit_start_q  <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      ovf_q        <= ovf_d;
      hit_valid_q  <= hit_valid_d;
      hit_start_q  <= hit_start_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_xfer) begin
      out_data_q <= OUT_W'({ovf_d, res_pos, res_found});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The counter only stops at its top value.
  `SFMF_ASSERT(a_ovf_at_max, ovf_q |-> (byte_index_q == POS_MAX))
  // A recorded match never starts past the current position.
  `SFMF_ASSERT(a_hit_behind_index, hit_valid_q |-> (hit_start_q <= byte_index_q))
  // End of text yields a result and a fresh search state.
  `SFMF_ASSERT(a_last_clears, last_xfer |=> (out_valid_q && !ovf_q && !hit_valid_q
                                             && (byte_index_q == '0)))
  // Window valid bits fill from the newest cell without gaps.
  `SFMF_ASSERT(a_fill_contiguous,
               ((chain_valid[PATTERN_MAX:1] >> 1) & ~chain_valid[PATTERN_MAX:1]) == '0)

endmodule

>>> rtl/core/sfmf_cell.sv
// Window cell: holds one text byte, passes it on, and compares its input to its pattern byte.
`timescale 1ns / 1ps
module sfmf_cell import sfmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [SEL_W-1:0]  cell_idx_i,
  input  pat_arr_t          pattern_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              valid_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              valid_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q;
  logic              valid_q;
  logic              in_use;
  logic [LEN_W-1:0]  sel;

  // Newest byte is the input of cell 0, so the input of cell i lines up with pattern byte len-1-i.
  assign in_use = LEN_W'(cell_idx_i) < ctrl_i.len;
  assign sel    = ctrl_i.len - LEN_W'(1) - LEN_W'(cell_idx_i);
  assign hit_o  = !in_use || (valid_i && (byte_i == pattern_i[sel[SEL_W-1:0]]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule
